FILE: src/dtpc_pkg.sv
// Shared types and constants for the decimal trie prefix checker.
package dtpc_pkg;

  localparam int DIGIT_W = 4;

  typedef enum logic [0:0] {
    OP_DIGIT = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LINK,
    S_NODE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;
  } item_t;

  typedef struct packed {
    logic number_ok;
    logic list_consistent;
    logic table_full;
  } result_t;

endpackage

FILE: src/dtpc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module dtpc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/decimal_trie_prefix_checker_core.sv
// Top level of the decimal trie prefix checker: walk control, trie state and result register.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+---------------------------------------
//  item in  | item (item_t)             | taken when start && !busy
//  result   | result (result_t)         | result_valid high for one cycle
//
// A clear item gives no result; busy stays low.
// A digit item passes through the child link read, the read of the
// child's node record, then the decision and any write back. The two
// memory reads are serial. A last digit gives its result in the cycle
// after the decision, while the next item may already be taken.
// Reset (rst, synchronous) leaves the root alone in the trie with every
// flag clear; the memories need no clearing, since a link counts only when
// the child it names was allocated in the current list under that very
// parent and digit. The receiver cannot stall results.
module decimal_trie_prefix_checker_core
  import dtpc_pkg::*;
#(
  parameter int NODE_COUNT = 4096,
  parameter int FANOUT     = 10
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    result_valid,
  output result_t result
);

  localparam int IW     = $clog2(NODE_COUNT);       // node index
  localparam int UW     = $clog2(NODE_COUNT + 1);   // node count
  localparam int LDEPTH = NODE_COUNT * FANOUT;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int NW     = IW + DIGIT_W + 1;         // node record {parent, digit, terminal}

  state_t state, state_next;

  // walk state
  logic [UW-1:0]      nodes_used, nodes_used_next;
  logic [IW-1:0]      cur, cur_next;
  logic [IW-1:0]      cur_parent, cur_parent_next;
  logic [DIGIT_W-1:0] cur_digit, cur_digit_next;
  logic               cur_term, cur_term_next;
  logic               number_failed, number_failed_next;
  logic               list_failed, list_failed_next;
  logic               pool_overflow, pool_overflow_next;

  // latched item
  logic [DIGIT_W-1:0] dig;
  logic               last;
  logic [LAW-1:0]     slot;
  logic [LAW-1:0]     slot_in;

  // memory ports
  logic               link_we;
  logic [LAW-1:0]     link_raddr;
  logic [IW-1:0]      link_rdata;
  logic               node_we;
  logic [IW-1:0]      node_waddr;
  logic [NW-1:0]      node_wdata;
  logic [NW-1:0]      node_rdata;

  logic               accept;
  logic               result_valid_next;
  result_t            result_next;

  // decision terms
  logic [IW-1:0]      n_parent;
  logic [DIGIT_W-1:0] n_digit;
  logic               n_term;
  logic               digit_ok;
  logic               link_ok;
  logic               pool_full;
  logic               fail_now;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign slot_in = LAW'(cur) * LAW'(FANOUT) + LAW'(item.digit);
  // hold the link read on the latched slot while the item is in flight
  assign link_raddr = busy ? slot : slot_in;

  assign n_parent  = node_rdata[NW-1 -: IW];
  assign n_digit   = node_rdata[DIGIT_W:1];
  assign n_term    = node_rdata[0];
  assign digit_ok  = {1'b0, dig} < (DIGIT_W + 1)'(FANOUT);
  assign pool_full = (nodes_used == UW'(NODE_COUNT));
  // a stale link from an earlier list fails one of these checks
  assign link_ok   = (link_rdata != '0) && (UW'(link_rdata) < nodes_used)
                  && (n_parent == cur) && (n_digit == dig);

  // child links, one entry per node and digit
  dtpc_ram #(.DEPTH(LDEPTH), .WIDTH(IW)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (slot),
    .wdata (IW'(nodes_used)),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // node records: parent, digit taken from it, terminal mark
  dtpc_ram #(.DEPTH(NODE_COUNT), .WIDTH(NW)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (link_rdata),
    .rdata (node_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      nodes_used    <= UW'(1);
      cur           <= '0;
      cur_term      <= 1'b0;
      number_failed <= 1'b0;
      list_failed   <= 1'b0;
      pool_overflow <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      nodes_used    <= nodes_used_next;
      cur           <= cur_next;
      cur_term      <= cur_term_next;
      number_failed <= number_failed_next;
      list_failed   <= list_failed_next;
      pool_overflow <= pool_overflow_next;
      result_valid  <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_parent <= cur_parent_next;
    cur_digit  <= cur_digit_next;
    result     <= result_next;
    if (accept) begin
      dig  <= item.digit;
      last <= item.last_digit;
      slot <= slot_in;
    end
  end

  always_comb begin
    state_next         = state;
    nodes_used_next    = nodes_used;
    cur_next           = cur;
    cur_parent_next    = cur_parent;
    cur_digit_next     = cur_digit;
    cur_term_next      = cur_term;
    number_failed_next = number_failed;
    list_failed_next   = list_failed;
    pool_overflow_next = pool_overflow;
    result_valid_next  = 1'b0;
    result_next        = result;
    link_we            = 1'b0;
    node_we            = 1'b0;
    node_waddr         = cur;
    node_wdata         = {cur_parent, cur_digit, 1'b1};
    fail_now           = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.op == OP_CLEAR) begin
            nodes_used_next    = UW'(1);
            cur_next           = '0;
            cur_term_next      = 1'b0;
            number_failed_next = 1'b0;
            list_failed_next   = 1'b0;
            pool_overflow_next = 1'b0;
          end else begin
            state_next = S_LINK;
          end
        end
      end

      S_LINK: begin
        // child link now in hand, its node record is being read
        state_next = S_NODE;
      end

      S_NODE: begin
        state_next = S_IDLE;
        if (!number_failed) begin
          if (!digit_ok || cur_term) begin
            fail_now = 1'b1;
          end else if (link_ok) begin
            if (last) begin
              fail_now = 1'b1;           // duplicate, or prefix of an earlier number
            end else begin
              cur_next        = link_rdata;
              cur_parent_next = cur;
              cur_digit_next  = dig;
              cur_term_next   = n_term;
            end
          end else if (pool_full) begin
            fail_now           = 1'b1;
            pool_overflow_next = 1'b1;
          end else begin
            // allocate a fresh node; marked terminal at once if the number ends here
            link_we         = 1'b1;
            node_we         = 1'b1;
            node_waddr      = IW'(nodes_used);
            node_wdata      = {cur, dig, last};
            nodes_used_next = nodes_used + UW'(1);
            cur_next        = IW'(nodes_used);
            cur_parent_next = cur;
            cur_digit_next  = dig;
            cur_term_next   = 1'b0;
          end
          number_failed_next = fail_now;
        end

        if (last) begin
          result_valid_next           = 1'b1;
          result_next.number_ok       = !number_failed_next;
          result_next.list_consistent = !(list_failed || number_failed_next);
          result_next.table_full      = pool_overflow_next;
          list_failed_next            = list_failed || number_failed_next;
          cur_next                    = '0;
          cur_term_next               = 1'b0;
          number_failed_next          = 1'b0;
          pool_overflow_next          = 1'b0;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
